@@ rtl/core/glyph_text_pixel_generator_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the glyph text pixel generator
// Clocked, reset-qualified wrappers for concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef GLYPH_TEXT_PIXEL_GENERATOR_UNIT_MACROS_SVH
`define GLYPH_TEXT_PIXEL_GENERATOR_UNIT_MACROS_SVH

// Same-cycle implication.
`define GTPG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GTPG_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/gtpg_pkg.sv @@
// ----------------------------------------------------------------------------
// gtpg_pkg
// Shared types, constants and the 6x10 font ROM of the glyph generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gtpg_pkg;

  localparam int unsigned GlyphCols   = 6;
  localparam int unsigned GlyphPixels = 60;
  localparam int unsigned UpperBits   = 32;
  localparam int unsigned LowerBits   = 28;
  localparam int unsigned RomFirst    = 43;
  localparam int unsigned RomCount    = 48;
  localparam int unsigned AddrW       = 24;
  localparam int unsigned CursorW     = 16;
  localparam int unsigned IdxW        = $clog2(GlyphPixels);
  localparam int unsigned ColW        = $clog2(GlyphCols);
  localparam int unsigned ShiftMax    = 8;

  localparam logic [IdxW-1:0] PixLast = IdxW'(GlyphPixels - 1);
  localparam logic [ColW-1:0] ColLast = ColW'(GlyphCols - 1);

  // front/back queue
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // register map
  localparam int unsigned PaddrW = 5;
  localparam logic [2:0] RegStartColumn = 3'd0;
  localparam logic [2:0] RegStartRow    = 3'd1;
  localparam logic [2:0] RegImageWidth  = 3'd2;
  localparam logic [2:0] RegForeground  = 3'd3;
  localparam logic [2:0] RegShiftBack   = 3'd4;

  typedef enum logic [1:0] {
    ActWrite      = 2'd0,
    ActShiftRight = 2'd1,
    ActShiftLeft  = 2'd2,
    ActKeep       = 2'd3
  } action_e;

  typedef struct packed {
    logic [11:0]       start_column;
    logic [11:0]       start_row;
    logic [12:0]       image_width;
    logic [7:0]        foreground;
    logic signed [4:0] shift_back;
  } cfg_t;

  typedef struct packed {
    logic [GlyphPixels-1:0] glyph;
    logic [CursorW-1:0]     cursor;
  } job_t;

  // LSB is the top-left pixel; codes 43 ('+') to 90 ('Z').
  localparam logic [31:0] RomUpper [RomCount] = '{
    32'h1F104000, 32'h0, 32'h1F000000, 32'h0, 32'h0,
    32'h51451284, 32'h04105184, 32'h0841144E, 32'h0E10841F, 32'h4A28C208,
    32'h1334105F, 32'h4F04144E, 32'h0420841F, 32'h4E45144E, 32'h1E45144E,
    32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
    32'hD1451284, 32'h8E49248F, 32'h4104144E, 32'h9249248F, 32'h4F04105F,
    32'h4F04105F, 32'h4104144E, 32'h5F451451, 32'h0410410E, 32'h0820821C,
    32'h43149451, 32'h41041041, 32'h5555B451, 32'h555534D1, 32'h5145144E,
    32'h4F45144F, 32'h5145144E, 32'h4F45144F, 32'h0E04144E, 32'h0410411F,
    32'h51451451, 32'h8A451451, 32'h55451451, 32'h8428A451, 32'h0428A451,
    32'h8420841F
  };

  localparam logic [31:0] RomLower [RomCount] = '{
    32'h0000041, 32'h0, 32'h0000000, 32'h10E1000, 32'h0,
    32'h0042914, 32'h01F1041, 32'h01F0421, 32'h00E4504, 32'h00821F2,
    32'h00E4504, 32'h00E4514, 32'h0020821, 32'h00E4514, 32'h00E4504,
    32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
    32'h0114517, 32'h00F4924, 32'h00E4410, 32'h00F4924, 32'h01F0410,
    32'h0010410, 32'h00E4516, 32'h0114514, 32'h00E1041, 32'h0062482,
    32'h0114491, 32'h01F0410, 32'h0114514, 32'h0114596, 32'h00E4514,
    32'h0010410, 32'h40E5514, 32'h0114491, 32'h00E4504, 32'h0041041,
    32'h00E4514, 32'h00410A2, 32'h00A5555, 32'h01144A2, 32'h0041041,
    32'h01F0420
  };

  function automatic logic [GlyphPixels-1:0] glyph_bits(logic [6:0] code);
    logic [6:0] idx;
    logic [GlyphPixels-1:0] bits;
    idx  = code - 7'(RomFirst);
    bits = '0;
    if ((code >= 7'(RomFirst)) && (idx < 7'(RomCount))) begin
      bits = {RomLower[idx[5:0]][LowerBits-1:0], RomUpper[idx[5:0]]};
    end
    return bits;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/gtpg_front.sv @@
// ----------------------------------------------------------------------------
// gtpg_front
// Accepts characters, fetches their glyphs and places them at the cursor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gtpg_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [6:0]       character_i,
  input  wire logic             new_string_i,
  input  wire logic [11:0]      start_column_i,
  input  wire logic             q_full_i,
  output logic                  q_push_o,
  output gtpg_pkg::job_t        q_job_o
);
  import gtpg_pkg::*;

  logic [CursorW-1:0] cursor_q, cursor_d;
  logic [CursorW-1:0] place;

  assign full     = q_full_i;
  assign q_push_o = push && !q_full_i;

  // restart happens before drawing
  assign place = new_string_i ? CursorW'(start_column_i) : cursor_q;

  assign q_job_o.glyph  = glyph_bits(character_i);
  assign q_job_o.cursor = place;

  assign cursor_d = q_push_o ? place + CursorW'(GlyphCols) : cursor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
    end else begin
      cursor_q <= cursor_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/gtpg_queue.sv @@
// ----------------------------------------------------------------------------
// gtpg_queue
// Short FIFO of glyph jobs between the front and the back sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gtpg_queue (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  gtpg_pkg::job_t wdata_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output logic           valid_o,
  output gtpg_pkg::job_t rdata_o
);
  import gtpg_pkg::*;

  job_t             entry_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == QCntW'(QDepth));
  assign valid_o = (count_q != '0);
  assign rdata_o = entry_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/gtpg_back.sv @@
// ----------------------------------------------------------------------------
// gtpg_back
// Pixel sequencer: walks a glyph in raster order, one command per cycle while pop keeps up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gtpg_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  gtpg_pkg::cfg_t                     cfg_i,
  input  wire logic                          job_valid_i,
  input  gtpg_pkg::job_t                     job_i,
  output logic                               job_pop_o,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [gtpg_pkg::AddrW-1:0]         pixel_address_o,
  output gtpg_pkg::action_e                  action_o,
  output logic [7:0]                         pixel_value_o,
  output logic [3:0]                         shift_count_o,
  output logic                               last_o
);
  import gtpg_pkg::*;

  // sequencer state
  logic                   act_q;
  logic [IdxW-1:0]        idx_q;
  logic [ColW-1:0]        col_q;
  logic [GlyphPixels-1:0] glyph_q;
  logic [AddrW-1:0]       addr_q, row_q;
  logic [AddrW-1:0]       prod_q;

  // output register
  logic out_valid_q;

  logic             out_rdy, emit, finish, load;
  logic [AddrW-1:0] base, row_next;
  logic [4:0]       mag5;
  logic [3:0]       mag;
  action_e          bg_action;

  // start_row * image_width; the user must keep config stable while items are in flight (not enforced)
  always_ff @(posedge clk_i) begin
    prod_q <= AddrW'(cfg_i.start_row) * AddrW'(cfg_i.image_width);
  end

  // background command
  assign mag5 = cfg_i.shift_back[4] ? (5'd0 - cfg_i.shift_back) : cfg_i.shift_back;
  assign mag  = (mag5 > 5'(ShiftMax)) ? 4'(ShiftMax) : mag5[3:0];

  always_comb begin
    priority if (cfg_i.shift_back[4]) begin
      bg_action = ActShiftRight;
    end else if (cfg_i.shift_back != '0) begin
      bg_action = ActShiftLeft;
    end else begin
      bg_action = ActKeep;
    end
  end

  assign out_rdy   = !out_valid_q || pop;
  assign emit      = act_q && out_rdy;
  assign finish    = emit && (idx_q == PixLast);
  assign load      = (!act_q || finish) && job_valid_i;
  assign job_pop_o = load;
  assign empty     = !out_valid_q;

  assign base     = prod_q + AddrW'(job_i.cursor);
  assign row_next = row_q + AddrW'(cfg_i.image_width);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q       <= 1'b0;
      idx_q       <= '0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        act_q <= 1'b1;
        idx_q <= '0;
        col_q <= '0;
      end else if (emit) begin
        if (finish) begin
          act_q <= 1'b0;
        end
        idx_q <= idx_q + 1'b1;
        col_q <= (col_q == ColLast) ? '0 : col_q + 1'b1;
      end
      if (out_rdy) begin
        out_valid_q <= act_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      glyph_q <= job_i.glyph;
      addr_q  <= base;
      row_q   <= base;
    end else if (emit) begin
      glyph_q <= glyph_q >> 1;
      if (col_q == ColLast) begin
        row_q  <= row_next;
        addr_q <= row_next;
      end else begin
        addr_q <= addr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      pixel_address_o <= addr_q;
      last_o          <= (idx_q == PixLast);
      if (glyph_q[0]) begin
        action_o      <= ActWrite;
        pixel_value_o <= cfg_i.foreground;
        shift_count_o <= '0;
      end else begin
        action_o      <= bg_action;
        pixel_value_o <= '0;
        shift_count_o <= (bg_action == ActKeep) ? 4'd0 : mag;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/glyph_text_pixel_generator_unit.sv @@
// ----------------------------------------------------------------------------
// glyph_text_pixel_generator_unit
// 6x10 bitmap font character generator emitting per-pixel draw commands.
// ----------------------------------------------------------------------------
// Each pushed ASCII character becomes 60 pixel commands in raster order
// (left to right, top to bottom), one command per clock while pop keeps up.
// The back-end pixel sequencer issues exactly one command per cycle while pop
// keeps up and moves on to the next queued glyph without a gap. The front end
// takes a new character in the cycle it is pushed, looks up its glyph and
// places it at the text cursor; up to two characters wait in the job queue
// behind the one being drawn, and full holds push off while the queue is full.
// With the block idle, a push is written to the job queue, loaded into the
// sequencer state and then registered in the output register before the first
// command shows. The user must write registers over the APB port only while no
// transaction is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module glyph_text_pixel_generator_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // character input
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [6:0]                    character_i,
  input  wire logic                          new_string_i,
  // pixel command output
  output logic                               empty,
  input  wire logic                          pop,
  output logic [gtpg_pkg::AddrW-1:0]         pixel_address_o,
  output gtpg_pkg::action_e                  action_o,
  output logic [7:0]                         pixel_value_o,
  output logic [3:0]                         shift_count_o,
  output logic                               last_o,
  // APB register port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [gtpg_pkg::PaddrW-1:0]   paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import gtpg_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;

  logic q_full, q_push, q_valid, q_pop;
  job_t q_wdata, q_rdata;

  // --------------------------------------------------------------------------
  // Register file. Word index is paddr[4:2]; unmapped words read as zero and
  // ignore writes.
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[PaddrW-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_column <= '0;
      cfg_q.start_row    <= '0;
      cfg_q.image_width  <= 13'd64;
      cfg_q.foreground   <= 8'd255;
      cfg_q.shift_back   <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegStartColumn: cfg_q.start_column <= pwdata[11:0];
        RegStartRow:    cfg_q.start_row    <= pwdata[11:0];
        RegImageWidth:  cfg_q.image_width  <= pwdata[12:0];
        RegForeground:  cfg_q.foreground   <= pwdata[7:0];
        RegShiftBack:   cfg_q.shift_back   <= pwdata[4:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegStartColumn: prdata = 32'(cfg_q.start_column);
      RegStartRow:    prdata = 32'(cfg_q.start_row);
      RegImageWidth:  prdata = 32'(cfg_q.image_width);
      RegForeground:  prdata = 32'(cfg_q.foreground);
      RegShiftBack:   prdata = {27'd0, cfg_q.shift_back};
      default:        prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Front end: glyph lookup and cursor placement.
  // --------------------------------------------------------------------------
  gtpg_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .character_i    (character_i),
    .new_string_i   (new_string_i),
    .start_column_i (cfg_q.start_column),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_job_o        (q_wdata)
  );

  // --------------------------------------------------------------------------
  // Job queue decoupling front and back.
  // --------------------------------------------------------------------------
  gtpg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  // --------------------------------------------------------------------------
  // Back end: raster walk with incremental addressing, registered output.
  // --------------------------------------------------------------------------
  gtpg_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .job_valid_i     (q_valid),
    .job_i           (q_rdata),
    .job_pop_o       (q_pop),
    .empty           (empty),
    .pop             (pop),
    .pixel_address_o (pixel_address_o),
    .action_o        (action_o),
    .pixel_value_o   (pixel_value_o),
    .shift_count_o   (shift_count_o),
    .last_o          (last_o)
  );

endmodule

`default_nettype wire

@@ rtl/core/gtpg_checker.sv @@
// ----------------------------------------------------------------------------
// gtpg_checker
// Port-level checks on the pixel command stream, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "glyph_text_pixel_generator_unit_macros.svh"

module gtpg_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        empty,
  input wire logic                        pop,
  input wire logic [gtpg_pkg::AddrW-1:0]  pixel_address_o,
  input gtpg_pkg::action_e                action_o,
  input wire logic [7:0]                  pixel_value_o,
  input wire logic [3:0]                  shift_count_o
);
  import gtpg_pkg::*;

  // a stalled command must hold
  `GTPG_ASSERT_NXT(a_hold, !empty && !pop, !empty && $stable(pixel_address_o), "stalled command changed")

  // only foreground writes carry a value
  `GTPG_ASSERT_IMP(a_value, !empty && action_o != ActWrite, pixel_value_o == 8'd0, "value on non-write")

  // shifts carry a magnitude from one to eight
  `GTPG_ASSERT_IMP(a_shift, !empty && (action_o == ActShiftRight || action_o == ActShiftLeft), shift_count_o != 4'd0 && shift_count_o <= 4'd8, "shift count out of range")

  // writes and untouched pixels carry no shift
  `GTPG_ASSERT_IMP(a_noshift, !empty && (action_o == ActWrite || action_o == ActKeep), shift_count_o == 4'd0, "shift count on non-shift")

endmodule

bind glyph_text_pixel_generator_unit gtpg_checker u_checker (.*);

`default_nettype wire
